@@ hdl/raid_parity_check_and_recover_assert.svh @@
// ----------------------------------------------------------------------------
// raid parity check assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RAID_PARITY_CHECK_AND_RECOVER_ASSERT_SVH
`define RAID_PARITY_CHECK_AND_RECOVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define RPCR_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("same-cycle check failed");
`define RPCR_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define RPCR_ASSERT_IMP(lbl, ant, cons)
`define RPCR_ASSERT_NXT(lbl, ant, cons)
`endif

`endif

@@ hdl/rpcr_pkg.sv @@
// ----------------------------------------------------------------------------
// rpcr_pkg
// constants, register indexes and the sequencer program of the parity block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpcr_pkg;

  localparam int LANES         = 8;
  localparam int MAX_DISKS     = 8;
  localparam int MAX_UNIT_BITS = 64;
  localparam int DISK_CAP_RAW  = (MAX_DISKS < LANES) ? MAX_DISKS : LANES;
  localparam int DISK_CAP      = (DISK_CAP_RAW < 2) ? 2 : DISK_CAP_RAW;
  localparam int DATA_W        = 64;
  localparam int CFG_ADDR_W    = 2;
  localparam int DISK_W        = 3;
  localparam int DC_W          = 4;
  localparam int UB_REG_W      = 7;

  localparam logic            PARITY_ODD_RST = 1'b0;
  localparam logic [DC_W-1:0] DISK_COUNT_RST = 4'd3;
  localparam logic [6:0]      UNIT_BITS_RST  = 7'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PARITY_ODD = 2'd0,
    REG_DISK_COUNT = 2'd1,
    REG_UNIT_BITS  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    STEP_FETCH   = 3'b001,
    STEP_EMIT    = 3'b010,
    STEP_VERDICT = 3'b100
  } step_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_DATA,
    EMIT_VERDICT
  } emit_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_BUSY,
    COND_UNIT_END,
    COND_LAST_PEND
  } cond_t;

  typedef struct packed {
    logic  take_in;
    emit_t emit;
    cond_t cond1;
    step_t tgt1;
    cond_t cond2;
    step_t tgt2;
    step_t dflt;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    unique case (step)
      STEP_FETCH:   w = '{1'b1, EMIT_NONE, COND_UNIT_END, STEP_EMIT,
                          COND_NEVER, STEP_FETCH, STEP_FETCH};
      STEP_EMIT:    w = '{1'b0, EMIT_DATA, COND_BUSY, STEP_EMIT,
                          COND_LAST_PEND, STEP_VERDICT, STEP_FETCH};
      STEP_VERDICT: w = '{1'b0, EMIT_VERDICT, COND_BUSY, STEP_VERDICT,
                          COND_NEVER, STEP_FETCH, STEP_FETCH};
      default:      w = '{1'b0, EMIT_NONE, COND_NEVER, STEP_FETCH,
                          COND_NEVER, STEP_FETCH, STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ hdl/rpcr_if.sv @@
// ----------------------------------------------------------------------------
// rpcr channel interfaces
// column input, result output and register write channels
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rpcr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] disk_bits;
  logic [7:0] erased_mask;
  logic       last_column;
  modport source (output valid, disk_bits, erased_mask, last_column, input ready);
  modport sink   (input valid, disk_bits, erased_mask, last_column, output ready);
endinterface

interface rpcr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  disk_index;
  logic [63:0] unit_data;
  logic        set_valid;
  logic        last;
  modport source (output valid, kind, disk_index, unit_data, set_valid, last,
                  input ready);
  modport sink   (input valid, kind, disk_index, unit_data, set_valid, last,
                  output ready);
endinterface

interface rpcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] addr;
  logic [7:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ hdl/raid_parity_check_and_recover.sv @@
// ----------------------------------------------------------------------------
// raid_parity_check_and_recover
// xor parity check and single-erasure rebuild, one bit column per transfer
// ----------------------------------------------------------------------------
// One column is taken per cycle while a stripe unit fills. When a unit ends
// (unit_bits columns, or a last column) the sequencer walks the disks one per
// cycle, emitting each data disk's unit and skipping the parity disk, but
// holds on a data disk while the output register is stalled; a last column
// then adds a verdict. No column is taken during that walk. Results pass
// through a single output register, so the consumer may stall at will.
// Registers are written through the cfg channel, which is always ready.
`timescale 1ns / 1ps
`default_nettype none

module raid_parity_check_and_recover #(
  parameter int MAX_UNIT_BITS = rpcr_pkg::MAX_UNIT_BITS
) (
  input  wire        clk,
  input  wire        rst_n,
  rpcr_in_if.sink    in_ch,
  rpcr_out_if.source out_ch,
  rpcr_cfg_if.sink   cfg_ch
);
  import rpcr_pkg::*;

  localparam int W     = MAX_UNIT_BITS;
  localparam int CNT_W = $clog2(MAX_UNIT_BITS + 1);

  logic                parity_odd_r;
  logic [DC_W-1:0]     disk_count_r;
  logic [UB_REG_W-1:0] unit_bits_r;

  step_t               step_r, step_nxt;
  logic [W-1:0]        shift_r [LANES];
  logic [W-1:0]        shift_nxt [LANES];
  logic [CNT_W-1:0]    column_r, column_nxt;
  logic [DISK_W-1:0]   parity_disk_r, parity_disk_nxt;
  logic [DISK_W-1:0]   disk_idx_r, disk_idx_nxt;
  logic                set_bad_r, set_bad_nxt;
  logic                last_pend_r, last_pend_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_kind_r;
  logic [DISK_W-1:0]   out_disk_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_set_valid_r;
  logic                out_last_r;

  ctrl_t               ctrl;
  logic [DC_W-1:0]     dc_eff;
  logic [CNT_W-1:0]    ub_eff;
  logic [LANES-1:0]    dmask, er, raw, col_bits;
  logic                er_none, er_one, par, bad_col;
  logic [CNT_W-1:0]    cnt;
  logic                in_xfer, unit_end, out_free;
  logic                skip, advance, idx_last, walk_done;
  logic [DISK_W-1:0]   dc_m1, last_data_idx;
  logic [CNT_W-1:0]    pad;
  logic [W-1:0]        umask, lane_data;
  logic                load_data, load_verd, step_busy, c1, c2;

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_odd_r <= PARITY_ODD_RST;
      disk_count_r <= DISK_COUNT_RST;
      unit_bits_r  <= UNIT_BITS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        REG_PARITY_ODD: parity_odd_r <= cfg_ch.data[0];
        REG_DISK_COUNT: disk_count_r <= cfg_ch.data[DC_W-1:0];
        REG_UNIT_BITS:  unit_bits_r  <= cfg_ch.data[UB_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes
  always_comb begin
    if (disk_count_r < DC_W'(2)) dc_eff = DC_W'(2);
    else if (disk_count_r > DC_W'(DISK_CAP)) dc_eff = DC_W'(DISK_CAP);
    else dc_eff = disk_count_r;
    if (unit_bits_r == '0) ub_eff = CNT_W'(1);
    else if (unit_bits_r > UB_REG_W'(MAX_UNIT_BITS)) ub_eff = CNT_W'(MAX_UNIT_BITS);
    else ub_eff = CNT_W'(unit_bits_r);
  end

  // column check and rebuild
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      dmask[i] = (DC_W'(i) < dc_eff);
    end
    er       = in_ch.erased_mask & dmask;
    raw      = in_ch.disk_bits & dmask & ~er;
    er_none  = (er == '0);
    er_one   = $onehot(er);
    par      = (^raw) ^ parity_odd_r;
    col_bits = (er_one && par) ? (raw | er) : raw;
    bad_col  = (er_none && par) || (!er_none && !er_one);
  end

  // sequencer
  assign ctrl         = ucode(step_r);
  assign in_ch.ready  = ctrl.take_in;
  assign in_xfer      = in_ch.valid && ctrl.take_in;
  assign cnt          = column_r + CNT_W'(1);
  assign unit_end     = (cnt >= ub_eff) || in_ch.last_column;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign dc_m1         = DISK_W'(dc_eff - DC_W'(1));
  assign last_data_idx = (parity_disk_r == dc_m1) ? DISK_W'(dc_eff - DC_W'(2)) : dc_m1;
  assign skip          = (disk_idx_r == parity_disk_r);
  assign advance       = skip || out_free;
  assign idx_last      = (disk_idx_r == dc_m1);
  assign walk_done     = advance && idx_last;
  assign load_data     = (ctrl.emit == EMIT_DATA) && !skip && out_free;
  assign load_verd     = (ctrl.emit == EMIT_VERDICT) && out_free;

  assign pad       = (column_r < ub_eff) ? CNT_W'(ub_eff - column_r) : '0;
  assign umask     = ~({W{1'b1}} << ub_eff);
  assign lane_data = (shift_r[disk_idx_r] << pad) & umask;

  always_comb begin
    unique case (ctrl.emit)
      EMIT_DATA:    step_busy = !walk_done;
      EMIT_VERDICT: step_busy = !out_free;
      default:      step_busy = !in_xfer;
    endcase
  end

  function automatic logic cond_eval(input cond_t c, input logic busy,
                                     input logic uend, input logic lpend);
    logic r;
    unique case (c)
      COND_BUSY:      r = busy;
      COND_UNIT_END:  r = uend;
      COND_LAST_PEND: r = lpend;
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  assign c1 = cond_eval(ctrl.cond1, step_busy, in_xfer && unit_end, last_pend_r);
  assign c2 = cond_eval(ctrl.cond2, step_busy, in_xfer && unit_end, last_pend_r);

  always_comb begin
    step_nxt        = c1 ? ctrl.tgt1 : (c2 ? ctrl.tgt2 : ctrl.dflt);
    shift_nxt       = shift_r;
    column_nxt      = column_r;
    parity_disk_nxt = parity_disk_r;
    disk_idx_nxt    = disk_idx_r;
    set_bad_nxt     = set_bad_r;
    last_pend_nxt   = last_pend_r;
    if (in_xfer) begin
      for (int i = 0; i < LANES; i++) begin
        shift_nxt[i] = (shift_r[i] << 1) | W'(col_bits[i]);
      end
      column_nxt    = cnt;
      set_bad_nxt   = set_bad_r | bad_col;
      last_pend_nxt = in_ch.last_column;
    end
    if (ctrl.emit == EMIT_DATA && advance) begin
      disk_idx_nxt = disk_idx_r + DISK_W'(1);
      if (idx_last) begin
        for (int i = 0; i < LANES; i++) shift_nxt[i] = '0;
        column_nxt      = '0;
        disk_idx_nxt    = '0;
        parity_disk_nxt = ((DC_W'(parity_disk_r) + DC_W'(1)) >= dc_eff) ?
                          '0 : parity_disk_r + DISK_W'(1);
      end
    end
    if (load_verd) begin
      for (int i = 0; i < LANES; i++) shift_nxt[i] = '0;
      column_nxt      = '0;
      parity_disk_nxt = '0;
      set_bad_nxt     = 1'b0;
      last_pend_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r        <= STEP_FETCH;
      column_r      <= '0;
      parity_disk_r <= '0;
      disk_idx_r    <= '0;
      set_bad_r     <= 1'b0;
      last_pend_r   <= 1'b0;
      for (int i = 0; i < LANES; i++) shift_r[i] <= '0;
    end else begin
      step_r        <= step_nxt;
      column_r      <= column_nxt;
      parity_disk_r <= parity_disk_nxt;
      disk_idx_r    <= disk_idx_nxt;
      set_bad_r     <= set_bad_nxt;
      last_pend_r   <= last_pend_nxt;
      shift_r       <= shift_nxt;
    end
  end

  // output register
  assign out_valid_nxt = (load_data || load_verd) ? 1'b1 :
                         (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data) begin
      out_kind_r      <= 1'b0;
      out_disk_r      <= disk_idx_r;
      out_data_r      <= DATA_W'(lane_data);
      out_set_valid_r <= !set_bad_r;
      out_last_r      <= (disk_idx_r == last_data_idx) && !last_pend_r;
    end else if (load_verd) begin
      out_kind_r      <= 1'b1;
      out_disk_r      <= '0;
      out_data_r      <= '0;
      out_set_valid_r <= !set_bad_r;
      out_last_r      <= 1'b1;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.disk_index = out_disk_r;
  assign out_ch.unit_data  = out_data_r;
  assign out_ch.set_valid  = out_set_valid_r;
  assign out_ch.last       = out_last_r;

  // checks
  `include "raid_parity_check_and_recover_assert.svh"

  `RPCR_ASSERT_IMP(a_take_only_in_fetch, in_ch.valid && in_ch.ready, step_r == STEP_FETCH)
  `RPCR_ASSERT_IMP(a_verdict_is_last, out_valid_r && out_kind_r, out_last_r)
  `RPCR_ASSERT_NXT(a_set_cleared, load_verd, (column_r == '0) && !set_bad_r && !last_pend_r)

endmodule

`default_nettype wire
